// ----- rtl/lsdt_pkg.sv -----
// Shared types, constants and state encoding for the load stride detect table.
package lsdt_pkg;

    // Default geometry
    localparam int NUM_SETS_DEF  = 64;
    localparam int NUM_WAYS_DEF  = 4;
    localparam int HIST_BINS_DEF = 64;

    // Field widths
    localparam int PC_W     = 64;
    localparam int ADDR_W   = 64;
    localparam int RSIZE_W  = 7;
    localparam int STRIDE_W = 64;
    localparam int CONF_W   = 8;
    localparam int CNT_W    = 32;
    localparam int VSIZE_W  = 16;
    localparam int BIDX_W   = 6;
    localparam int OWAY_W   = 2;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 184;

    localparam logic [CONF_W-1:0]  CONF_MIN     = 8'd2;
    localparam logic [CONF_W-1:0]  CONF_MAX     = 8'd255;
    localparam logic [CNT_W-1:0]   CNT_MAX      = 32'hFFFF_FFFF;
    localparam logic [VSIZE_W-1:0] VSIZE_RESET  = 16'd64;

    // One table entry
    typedef struct packed {
        logic [PC_W-1:0]     pc;
        logic [ADDR_W-1:0]   prev_addr;
        logic [STRIDE_W-1:0] stride;
        logic [CONF_W-1:0]   confidence;
    } entry_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]    vectorizable_total;
        logic [CNT_W-1:0]    total_strides;
        logic [CNT_W-1:0]    bin_count;
        logic [BIDX_W-1:0]   bin_index;
        logic                vectorizable;
        logic                bin_overflow;
        logic                counted;
        logic [CONF_W-1:0]   confidence;
        logic [STRIDE_W-1:0] stride;
        logic [OWAY_W-1:0]   way;
        logic                hit;
    } result_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETIDX,
        ST_READ,
        ST_CHECK,
        ST_UPDATE,
        ST_DIVIDE,
        ST_HIST_RD,
        ST_HIST_WR,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/load_stride_detect_table.sv -----
// Top level of the load stride detect table: sequencer, entry table and histogram.
//
// Use: one load per s_tvalid/s_tready beat on the slave stream (s_tdata =
// pc, load_address, read_size from bit 0 up). Each load yields exactly one
// result beat on the master stream (hit, way, stride, confidence, counted,
// bin_overflow, vectorizable, bin_index, bin_count, total_strides,
// vectorizable_total from bit 0 up). The vector width register is to be written
// over the cfg channel only while the block is idle; the block itself does not
// enforce this, and cfg_ready is always high. Per load the sequencer takes the
// beat in the idle state, then computes the set index (skipped when NUM_SETS is
// a power of two), reads and checks each way in turn for the table scan (one
// entry memory read port) and updates the entry; for a confident in-range
// stride it then runs the divider and reads and writes the histogram bin, and
// last it loads the output register.
// s_tready is high only while idle, so a new load is taken only once the
// previous result has been passed to the output register.
// The output register holds a finished result while the next load is taken;
// a stalled receiver holds the sequencer in its last state until the
// register frees. Reset clears all valid bits, the histogram (through
// per-bin valid bits), both totals, and sets the vector width to 64.
module load_stride_detect_table #(
    parameter int NUM_SETS  = lsdt_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS  = lsdt_pkg::NUM_WAYS_DEF,
    parameter int HIST_BINS = lsdt_pkg::HIST_BINS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pc[63:0], load_address[127:64], read_size[134:128]
    input  logic [lsdt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // hit, way, stride, confidence, counted, bin_overflow, vectorizable,
    // bin_index, bin_count, total_strides, vectorizable_total
    output logic [lsdt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lsdt_pkg::VSIZE_W-1:0]   cfg_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready
);

    localparam int NENT     = NUM_SETS * NUM_WAYS;
    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int IDX_W    = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int QW       = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int DW       = QW + lsdt_pkg::RSIZE_W;
    localparam int LIM_W    = lsdt_pkg::RSIZE_W + $clog2(HIST_BINS + 1);
    localparam bit SET_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

    lsdt_pkg::state_t state_reg, state_next;

    // Latched load
    logic [lsdt_pkg::PC_W-1:0]    pc_reg;
    logic [lsdt_pkg::ADDR_W-1:0]  addr_reg;
    logic [lsdt_pkg::RSIZE_W-1:0] rsize_reg;
    logic [SET_W-1:0]             set_reg;
    logic [SET_W:0]               res_reg, res_next;
    logic [3:0]                   nib_reg;

    // Scan bookkeeping
    logic [WAY_W-1:0]             way_reg;
    logic                         hit_reg;
    logic [WAY_W-1:0]             hit_way_reg;
    lsdt_pkg::entry_t             hit_entry_reg;
    logic                         free_reg;
    logic [WAY_W-1:0]             free_way_reg;
    logic [WAY_W-1:0]             vic_way_reg;
    logic [lsdt_pkg::PC_W-1:0]    vic_pc_reg;

    // Step results
    logic [WAY_W-1:0]              res_way_reg;
    logic [lsdt_pkg::STRIDE_W-1:0] stride_reg;
    logic [lsdt_pkg::CONF_W-1:0]   conf_reg;
    logic                          ovf_reg;
    logic                          counted_reg;
    logic                          vec_reg;
    logic [QW-1:0]                 bidx_reg;
    logic [lsdt_pkg::CNT_W-1:0]    bcnt_reg;
    logic [lsdt_pkg::CNT_W-1:0]    tot_reg;
    logic [lsdt_pkg::CNT_W-1:0]    vtot_reg;
    logic [lsdt_pkg::VSIZE_W-1:0]  vsize_reg;

    lsdt_pkg::result_t out_reg;
    logic              m_valid_reg;

    // Memories
    lsdt_pkg::entry_t           entry_mem [NENT];
    lsdt_pkg::entry_t           rd_entry_reg;
    logic [NENT-1:0]            valid_reg;
    logic [lsdt_pkg::CNT_W-1:0] hist_mem [HIST_BINS];
    logic [lsdt_pkg::CNT_W-1:0] hist_rd_reg;
    logic [HIST_BINS-1:0]       hvalid_reg;

    // Control
    logic                       accept;
    logic                       out_free;
    logic                       last_way;
    logic [IDX_W-1:0]           rd_idx;
    logic [IDX_W-1:0]           wr_idx;
    logic                       entry_we;
    lsdt_pkg::entry_t           entry_wdata;
    logic [WAY_W-1:0]           upd_way;
    logic                       cur_valid;

    // Update datapath
    logic                          back_step;
    logic [lsdt_pkg::STRIDE_W-1:0] step;
    logic                          same_step;
    logic [lsdt_pkg::STRIDE_W-1:0] stride_upd;
    logic [lsdt_pkg::CONF_W-1:0]   new_conf;
    logic                          confident;
    logic [LIM_W-1:0]              bin_lim;
    logic                          out_of_range;

    // Divider and histogram
    logic                          div_start;
    logic                          div_done;
    logic [QW-1:0]                 div_q;
    logic [lsdt_pkg::CNT_W-1:0]    hist_cur;
    logic [lsdt_pkg::CNT_W-1:0]    hist_new;
    logic                          hist_we;
    logic                          is_vec;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign last_way = (way_reg == WAY_W'(NUM_WAYS - 1));
    assign rd_idx   = IDX_W'(set_reg * NUM_WAYS) + IDX_W'(way_reg);
    assign cur_valid = valid_reg[rd_idx];

    // Set index residue, four pc bits per cycle
    always_comb
    begin
        logic [SET_W:0] t;
        t = res_reg;
        for (int i = 3; i >= 0; i--)
        begin
            t = {t[SET_W-1:0], pc_reg[{nib_reg, 2'b00} + 6'(i)]};
            if (t >= (SET_W+1)'(NUM_SETS))
            begin
                t = t - (SET_W+1)'(NUM_SETS);
            end
        end
        res_next = t;
    end

    // Hit update arithmetic
    always_comb
    begin
        back_step = addr_reg < hit_entry_reg.prev_addr;
        step      = addr_reg - hit_entry_reg.prev_addr;
        same_step = (step == hit_entry_reg.stride);
        if (back_step)
        begin
            stride_upd = '0;
            new_conf   = '0;
        end
        else if (same_step)
        begin
            stride_upd = hit_entry_reg.stride;
            new_conf   = (hit_entry_reg.confidence == lsdt_pkg::CONF_MAX) ?
                         hit_entry_reg.confidence : hit_entry_reg.confidence + 1'b1;
        end
        else
        begin
            stride_upd = step;
            new_conf   = '0;
        end
        confident    = hit_reg && !back_step && (new_conf >= lsdt_pkg::CONF_MIN);
        bin_lim      = LIM_W'(rsize_reg) * LIM_W'(HIST_BINS);
        out_of_range = (rsize_reg == '0) ||
                       (stride_upd >= lsdt_pkg::STRIDE_W'(bin_lim));
    end

    // Entry write selection
    always_comb
    begin
        priority if (hit_reg)
        begin
            upd_way = hit_way_reg;
        end
        else if (free_reg)
        begin
            upd_way = free_way_reg;
        end
        else
        begin
            upd_way = vic_way_reg;
        end
        wr_idx                   = IDX_W'(set_reg * NUM_WAYS) + IDX_W'(upd_way);
        entry_wdata.pc           = pc_reg;
        entry_wdata.prev_addr    = addr_reg;
        entry_wdata.stride       = hit_reg ? stride_upd : '0;
        entry_wdata.confidence   = hit_reg ? new_conf : '0;
    end

    // Histogram increment
    always_comb
    begin
        hist_cur = hvalid_reg[bidx_reg] ? hist_rd_reg : '0;
        hist_new = (hist_cur == lsdt_pkg::CNT_MAX) ? hist_cur : hist_cur + 1'b1;
        is_vec   = stride_reg <= lsdt_pkg::STRIDE_W'(vsize_reg >> 1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsdt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = SET_POW2 ? lsdt_pkg::ST_READ : lsdt_pkg::ST_SETIDX;
                end
            end
            lsdt_pkg::ST_SETIDX:
            begin
                if (nib_reg == '0)
                begin
                    state_next = lsdt_pkg::ST_READ;
                end
            end
            lsdt_pkg::ST_READ:
            begin
                state_next = lsdt_pkg::ST_CHECK;
            end
            lsdt_pkg::ST_CHECK:
            begin
                state_next = last_way ? lsdt_pkg::ST_UPDATE : lsdt_pkg::ST_READ;
            end
            lsdt_pkg::ST_UPDATE:
            begin
                state_next = (confident && !out_of_range) ? lsdt_pkg::ST_DIVIDE
                                                          : lsdt_pkg::ST_OUT;
            end
            lsdt_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = lsdt_pkg::ST_HIST_RD;
                end
            end
            lsdt_pkg::ST_HIST_RD:
            begin
                state_next = lsdt_pkg::ST_HIST_WR;
            end
            lsdt_pkg::ST_HIST_WR:
            begin
                state_next = lsdt_pkg::ST_OUT;
            end
            lsdt_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = lsdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsdt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready  = (state_reg == lsdt_pkg::ST_IDLE);
        cfg_ready = 1'b1;
        entry_we  = (state_reg == lsdt_pkg::ST_UPDATE);
        div_start = (state_reg == lsdt_pkg::ST_UPDATE) && confident && !out_of_range;
        hist_we   = (state_reg == lsdt_pkg::ST_HIST_WR);
    end

    // Entry memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[wr_idx] <= entry_wdata;
        end
        rd_entry_reg <= entry_mem[rd_idx];
    end

    // Histogram memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[bidx_reg] <= hist_new;
        end
        hist_rd_reg <= hist_mem[bidx_reg];
    end

    lsdt_div #(
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DW'(stride_upd)),
        .divisor  (rsize_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lsdt_pkg::ST_IDLE;
            valid_reg   <= '0;
            hvalid_reg  <= '0;
            tot_reg     <= '0;
            vtot_reg    <= '0;
            vsize_reg   <= lsdt_pkg::VSIZE_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                vsize_reg <= cfg_data;
            end
            if (entry_we)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (hist_we)
            begin
                hvalid_reg[bidx_reg] <= 1'b1;
                tot_reg <= (tot_reg == lsdt_pkg::CNT_MAX) ? tot_reg : tot_reg + 1'b1;
                if (is_vec)
                begin
                    vtot_reg <= (vtot_reg == lsdt_pkg::CNT_MAX) ? vtot_reg
                                                                : vtot_reg + 1'b1;
                end
            end
            if (state_reg == lsdt_pkg::ST_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            lsdt_pkg::ST_IDLE:
            begin
                pc_reg      <= s_tdata[63:0];
                addr_reg    <= s_tdata[127:64];
                rsize_reg   <= s_tdata[134:128];
                set_reg     <= s_tdata[SET_W-1:0] & SET_W'(NUM_SETS - 1);
                res_reg     <= '0;
                nib_reg     <= 4'hF;
                way_reg     <= '0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
                ovf_reg     <= 1'b0;
                counted_reg <= 1'b0;
                vec_reg     <= 1'b0;
                bidx_reg    <= '0;
                bcnt_reg    <= '0;
            end
            lsdt_pkg::ST_SETIDX:
            begin
                res_reg <= res_next;
                nib_reg <= nib_reg - 1'b1;
                set_reg <= res_next[SET_W-1:0];
            end
            lsdt_pkg::ST_READ:
            begin
            end
            lsdt_pkg::ST_CHECK:
            begin
                if (cur_valid && rd_entry_reg.pc == pc_reg && !hit_reg)
                begin
                    hit_reg       <= 1'b1;
                    hit_way_reg   <= way_reg;
                    hit_entry_reg <= rd_entry_reg;
                end
                if (!cur_valid && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_way_reg <= way_reg;
                end
                if (way_reg == '0 || rd_entry_reg.pc < vic_pc_reg)
                begin
                    vic_way_reg <= way_reg;
                    vic_pc_reg  <= rd_entry_reg.pc;
                end
                way_reg <= way_reg + 1'b1;
            end
            lsdt_pkg::ST_UPDATE:
            begin
                res_way_reg <= upd_way;
                stride_reg  <= hit_reg ? stride_upd : '0;
                conf_reg    <= hit_reg ? new_conf : '0;
                ovf_reg     <= confident && out_of_range;
            end
            lsdt_pkg::ST_DIVIDE:
            begin
                bidx_reg <= div_q;
            end
            lsdt_pkg::ST_HIST_RD:
            begin
            end
            lsdt_pkg::ST_HIST_WR:
            begin
                counted_reg <= 1'b1;
                bcnt_reg    <= hist_new;
                vec_reg     <= is_vec;
            end
            lsdt_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_reg.hit                <= hit_reg;
                    out_reg.way                <= lsdt_pkg::OWAY_W'(res_way_reg);
                    out_reg.stride             <= stride_reg;
                    out_reg.confidence         <= conf_reg;
                    out_reg.counted            <= counted_reg;
                    out_reg.bin_overflow       <= ovf_reg;
                    out_reg.vectorizable       <= vec_reg;
                    out_reg.bin_index          <= lsdt_pkg::BIDX_W'(bidx_reg);
                    out_reg.bin_count          <= bcnt_reg;
                    out_reg.total_strides      <= tot_reg;
                    out_reg.vectorizable_total <= vtot_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lsdt_pkg::M_TDATA_W - $bits(lsdt_pkg::result_t)){1'b0}}, out_reg};

    // Result consistency checks
    a_counted_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_reg.counted && out_reg.bin_overflow))
        else $error("counted and bin_overflow both set");

    a_vec_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && out_reg.vectorizable |-> out_reg.counted)
        else $error("vectorizable without counted");

    a_miss_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !out_reg.hit |-> out_reg.stride == '0 && !out_reg.counted)
        else $error("miss result carries stride or count");

    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        vtot_reg <= tot_reg)
        else $error("vectorizable total above strided total");

endmodule

// ----- rtl/lsdt_div.sv -----
// Iterative restoring divider: one quotient bit per cycle through a shared subtractor.
module lsdt_div #(
    parameter int QW = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [QW+lsdt_pkg::RSIZE_W-1:0]   dividend,
    input  logic [lsdt_pkg::RSIZE_W-1:0]      divisor,
    output logic                              done,
    output logic [QW-1:0]                     quotient
);

    localparam int DW  = QW + lsdt_pkg::RSIZE_W;
    localparam int CW  = $clog2(QW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          take;

    // Load on start, else one compare/subtract step while busy, then clear busy
    always_comb
    begin
        take      = (rem_reg >= dsr_reg);
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = DW'(divisor) << (QW - 1);
            quo_next  = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (take)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            quo_next = QW'({quo_reg, take});
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule
